@@ sv/i2c3ag_pkg.sv @@
// Shared types, constants and the geometry decode of the im2col 3D address generator.
package i2c3ag_pkg;

  // Field widths of the channels and registers.
  localparam int GEOM_W     = 43;
  localparam int CH_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int BASE_W     = 46;
  localparam int ROW_W      = 32;
  localparam int COL_W      = 34;
  localparam int ADDR_W     = 47;
  localparam int SIZE_FLD_W = 11;
  localparam int FILT_FLD_W = 8;
  localparam int PAD_W      = 8;
  localparam int STRIDE_W   = 8;

  // Bit positions inside a geometry register.
  localparam int SIZE_LSB   = 0;
  localparam int FILT_LSB   = 11;
  localparam int PL_LSB     = 19;
  localparam int PH_LSB     = 27;
  localparam int ST_LSB     = 35;

  // Register values after reset: size 1, filter 1, no padding, stride 1.
  localparam logic [GEOM_W-1:0] GEOM_RESET = 43'd34359740417;
  localparam logic [CH_W-1:0]   CH_RESET   = 11'd1;

  // Default limits for the size and filter fields.
  localparam int DEF_MAX_VOLUME_SIZE = 1024;
  localparam int DEF_MAX_FILTER_SIZE = 255;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_GEOM0    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM1    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

  // Input actions and result status codes.
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_STEP   = 1'b1;
  localparam logic ST_ELEMENT = 1'b0;
  localparam logic ST_DONE    = 1'b1;

  // One spatial dimension after clamping; a zero stride is already replaced by one.
  typedef struct packed {
    logic [SIZE_FLD_W-1:0] size;
    logic [FILT_FLD_W-1:0] filt;
    logic [PAD_W-1:0]      pl;
    logic [PAD_W-1:0]      ph;
    logic [STRIDE_W-1:0]   st;
  } dim_geom_t;

  // One element as the walker sees it, before the address arithmetic.
  typedef struct packed {
    logic                  status;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  inr;
    logic                  last;
    logic [CH_W-1:0]       ch;
    logic [SIZE_FLD_W-1:0] x;
    logic [SIZE_FLD_W-1:0] y;
    logic [SIZE_FLD_W-1:0] z;
    logic [BASE_W-1:0]     base;
  } elem_t;

  function automatic dim_geom_t unpack_geom(input logic [GEOM_W-1:0]     raw,
                                            input logic [SIZE_FLD_W-1:0] max_size,
                                            input logic [FILT_FLD_W-1:0] max_filt);
    dim_geom_t g;
    g.size = raw[SIZE_LSB +: SIZE_FLD_W];
    g.filt = raw[FILT_LSB +: FILT_FLD_W];
    g.pl   = raw[PL_LSB +: PAD_W];
    g.ph   = raw[PH_LSB +: PAD_W];
    g.st   = raw[ST_LSB +: STRIDE_W];
    if (g.size > max_size) g.size = max_size;
    if (g.filt > max_filt) g.filt = max_filt;
    if (g.st == '0) g.st = STRIDE_W'(1);
    return g;
  endfunction

endpackage

@@ sv/i2c3ag_if.sv @@
// Channel interfaces of the im2col 3D address generator: input, result and configuration.
interface i2c3ag_in_if import i2c3ag_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BASE_W-1:0] instance_base;

  modport source(output valid, action, instance_base, input ready);
  modport sink(input valid, action, instance_base, output ready);
endinterface

interface i2c3ag_out_if import i2c3ag_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ROW_W-1:0]  matrix_row;
  logic [COL_W-1:0]  matrix_column;
  logic [ADDR_W-1:0] source_address;
  logic              in_range;
  logic              last_element;

  modport source(output valid, status, matrix_row, matrix_column, source_address,
                 in_range, last_element, input ready);
  modport sink(input valid, status, matrix_row, matrix_column, source_address,
               in_range, last_element, output ready);
endinterface

interface i2c3ag_cfg_if import i2c3ag_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GEOM_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/im2col_3d_address_generator.sv @@
// Top level of the im2col 3D address generator: configuration registers, walker and address pipeline.
//
// This block walks the unrolled (im2col) matrix of one 3D instance volume with per-dimension
// low and high padding and stride. A start item (action 0) loads the instance base address,
// resets the walk and produces no result; it takes effect in the cycle it is accepted. Each step
// item (action 1) produces exactly one result: the next element's matrix row (output position,
// dim0 fastest), matrix column (filter tap, dim0 fastest, then channel), source address and
// an in-range flag, with last_element marking the final element. Padding elements report address
// zero and in_range zero, and a step with nothing left reports status 1 with all other fields zero.
// The block accepts one item every cycle while the pipeline has room. A step's result passes
// through the address pipeline, which registers the item and then forms the linear offset with
// three chained 11-bit multiply-adds, one per stage, and then adds the base. The walk state
// itself (window origins, tap counters, row and column counters) advances in the accept cycle,
// so consecutive steps never wait on each other. The pipeline is elastic: when the result side
// stalls, items pile up in the stages and ready drops only when every stage is full. The
// configuration registers are used live and must be written only while no step is in flight.
// There is no memory and no clearing pass after reset. Volume sizes above MAX_VOLUME_SIZE and
// filter sizes above MAX_FILTER_SIZE are clamped to those limits, and a zero stride acts as one.
module im2col_3d_address_generator import i2c3ag_pkg::*; #(
  parameter int MAX_VOLUME_SIZE = DEF_MAX_VOLUME_SIZE,
  parameter int MAX_FILTER_SIZE = DEF_MAX_FILTER_SIZE
) (
  input  logic         clk,
  input  logic         rst_n,
  i2c3ag_cfg_if.sink   cfg_ch,
  i2c3ag_in_if.sink    in_ch,
  i2c3ag_out_if.source out_ch
);

  logic [GEOM_W-1:0] geom_raw_r [3];
  logic [CH_W-1:0]   ch_count_r;
  dim_geom_t         geom [3];
  elem_t             elem;
  logic              take;
  logic              in_rdy;

  // The register file never stalls a write.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_raw_r[0] <= GEOM_RESET;
      geom_raw_r[1] <= GEOM_RESET;
      geom_raw_r[2] <= GEOM_RESET;
      ch_count_r    <= CH_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_GEOM0:    geom_raw_r[0] <= cfg_ch.data;
        REG_GEOM1:    geom_raw_r[1] <= cfg_ch.data;
        REG_GEOM2:    geom_raw_r[2] <= cfg_ch.data;
        REG_CHANNELS: ch_count_r    <= cfg_ch.data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode the packed geometry fields, applying the size limits and the zero-stride rule.
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      geom[d] = unpack_geom(geom_raw_r[d], SIZE_FLD_W'(MAX_VOLUME_SIZE),
                            FILT_FLD_W'(MAX_FILTER_SIZE));
    end
  end

  assign in_ch.ready = in_rdy;
  assign take        = in_ch.valid && in_rdy;

  i2c3ag_walker #(
    .MAX_VOLUME_SIZE(MAX_VOLUME_SIZE),
    .MAX_FILTER_SIZE(MAX_FILTER_SIZE)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .channels (ch_count_r),
    .take     (take),
    .action   (in_ch.action),
    .base_in  (in_ch.instance_base),
    .elem     (elem)
  );

  // Only step items carry a result into the pipeline.
  i2c3ag_addr_pipe u_addr_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .geom   (geom),
    .push   (take && (in_ch.action == ACT_STEP)),
    .elem   (elem),
    .in_rdy (in_rdy),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_done_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_DONE) |->
      (out_ch.matrix_row == '0) && (out_ch.matrix_column == '0) &&
      (out_ch.source_address == '0) && !out_ch.in_range && !out_ch.last_element)
    else $error("end-of-walk result carries nonzero fields");

  a_pad_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.in_range |-> (out_ch.source_address == '0))
    else $error("padding element carries a source address");

  a_last_is_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_element |-> (out_ch.status == ST_ELEMENT))
    else $error("final-element flag on a result without an element");
`endif

endmodule

@@ sv/i2c3ag_walker.sv @@
// Walk state of the unrolled matrix: window origins, tap counters, row and column counters.
module i2c3ag_walker import i2c3ag_pkg::*; #(
  parameter int MAX_VOLUME_SIZE = DEF_MAX_VOLUME_SIZE,
  parameter int MAX_FILTER_SIZE = DEF_MAX_FILTER_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dim_geom_t         geom [3],
  input  logic [CH_W-1:0]   channels,
  input  logic              take,
  input  logic              action,
  input  logic [BASE_W-1:0] base_in,
  output elem_t             elem
);

  // The origin runs from minus the low pad up to size plus high pad minus filter.
  localparam int ORIGIN_W = $clog2(MAX_VOLUME_SIZE + 256) + 1;
  localparam int CMP_W    = ORIGIN_W + 2;
  localparam int TAP_W    = (MAX_FILTER_SIZE > 1) ? $clog2(MAX_FILTER_SIZE + 1) : 1;

  logic                       active_r, active_nxt;
  logic [BASE_W-1:0]          base_r, base_nxt;
  logic signed [ORIGIN_W-1:0] origin_r [3];
  logic signed [ORIGIN_W-1:0] origin_nxt [3];
  logic [TAP_W-1:0]           tap_r [3];
  logic [TAP_W-1:0]           tap_nxt [3];
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;

  logic signed [CMP_W-1:0]    coord [3];
  logic signed [CMP_W-1:0]    size_s [3];
  logic signed [ORIGIN_W-1:0] origin_lo [3];
  logic signed [ORIGIN_W-1:0] origin_adv [3];
  logic [2:0]                 inr_d;
  logic [2:0]                 ofin;
  logic [2:0]                 tap_last;
  logic [2:0]                 nonempty_d;
  logic                       ch_last;
  logic                       col_final;
  logic                       row_final;
  logic                       last;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      coord[d]  = CMP_W'(origin_r[d]) + signed'(CMP_W'(tap_r[d]));
      size_s[d] = signed'(CMP_W'(geom[d].size));
      inr_d[d]  = (coord[d] >= 0) && (coord[d] < size_s[d]);
      // No further window position fits after this origin.
      ofin[d] = (CMP_W'(origin_r[d]) + signed'(CMP_W'(geom[d].st))) >
                (size_s[d] + signed'(CMP_W'(geom[d].ph)) - signed'(CMP_W'(geom[d].filt)));
      tap_last[d]   = (9'(tap_r[d]) + 9'd1) >= 9'(geom[d].filt);
      origin_lo[d]  = ORIGIN_W'(-signed'(CMP_W'(geom[d].pl)));
      origin_adv[d] = ORIGIN_W'(CMP_W'(origin_r[d]) + signed'(CMP_W'(geom[d].st)));
      nonempty_d[d] = (geom[d].filt != '0) &&
                      ((12'(geom[d].size) + 12'(geom[d].pl) + 12'(geom[d].ph)) >=
                       12'(geom[d].filt));
    end
  end

  assign ch_last   = (12'(ch_r) + 12'd1) >= 12'(channels);
  assign col_final = ch_last && (&tap_last);
  assign row_final = &ofin;
  assign last      = col_final && row_final;

  always_comb begin
    logic carry;
    carry      = 1'b0;
    active_nxt = active_r;
    base_nxt   = base_r;
    ch_nxt     = ch_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    for (int d = 0; d < 3; d++) begin
      origin_nxt[d] = origin_r[d];
      tap_nxt[d]    = tap_r[d];
    end
    if (take) begin
      if (action == ACT_START) begin
        base_nxt   = base_in;
        ch_nxt     = '0;
        row_nxt    = '0;
        col_nxt    = '0;
        active_nxt = (channels != '0) && (&nonempty_d);
        for (int d = 0; d < 3; d++) begin
          origin_nxt[d] = origin_lo[d];
          tap_nxt[d]    = '0;
        end
      end else if (active_r) begin
        carry = 1'b1;
        if (col_final) begin
          // End of a row: clear the taps and move the window like an odometer.
          ch_nxt  = '0;
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
          for (int d = 0; d < 3; d++) begin
            tap_nxt[d] = '0;
            if (carry) begin
              if (!ofin[d]) begin
                origin_nxt[d] = origin_adv[d];
                carry         = 1'b0;
              end else begin
                origin_nxt[d] = origin_lo[d];
              end
            end
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
          for (int d = 0; d < 3; d++) begin
            if (carry) begin
              if (!tap_last[d]) begin
                tap_nxt[d] = tap_r[d] + TAP_W'(1);
                carry      = 1'b0;
              end else begin
                tap_nxt[d] = '0;
              end
            end
          end
          if (carry) ch_nxt = ch_r + CH_W'(1);
        end
        if (last) active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      base_r   <= '0;
      ch_r     <= '0;
      row_r    <= '0;
      col_r    <= '0;
      for (int d = 0; d < 3; d++) begin
        origin_r[d] <= '0;
        tap_r[d]    <= '0;
      end
    end else begin
      active_r <= active_nxt;
      base_r   <= base_nxt;
      ch_r     <= ch_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      for (int d = 0; d < 3; d++) begin
        origin_r[d] <= origin_nxt[d];
        tap_r[d]    <= tap_nxt[d];
      end
    end
  end

  // An inactive walk reports that nothing remains, with every other field zero.
  always_comb begin
    elem = '0;
    if (!active_r) begin
      elem.status = ST_DONE;
    end else begin
      elem.status = ST_ELEMENT;
      elem.row    = row_r;
      elem.col    = col_r;
      elem.inr    = &inr_d;
      elem.last   = last;
      elem.ch     = ch_r;
      elem.x      = coord[0][SIZE_FLD_W-1:0];
      elem.y      = coord[1][SIZE_FLD_W-1:0];
      elem.z      = coord[2][SIZE_FLD_W-1:0];
      elem.base   = base_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    take && (action == ACT_STEP) && active_r && last |=> !active_r)
    else $error("walk still active after its final element");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && (action == ACT_START) |=> (row_r == '0) && (col_r == '0) && (ch_r == '0))
    else $error("start did not clear the row, column and channel counters");

  a_idle_step_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && (action == ACT_STEP) && !active_r |=> !active_r)
    else $error("step on an idle walk made it active");
`endif

endmodule

@@ sv/i2c3ag_addr_pipe.sv @@
// Elastic multiply-add pipeline that turns coordinates into the source address, with output register.
module i2c3ag_addr_pipe import i2c3ag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dim_geom_t            geom [3],
  input  logic                 push,
  input  elem_t                elem,
  output logic                 in_rdy,
  i2c3ag_out_if.source         out_ch
);

  localparam int T1_W = 2 * SIZE_FLD_W;
  localparam int T2_W = T1_W + SIZE_FLD_W;
  localparam int T3_W = T2_W + SIZE_FLD_W;

  typedef struct packed {
    logic             status;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             inr;
    logic             last;
  } meta_t;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic adv1, adv2, adv3, adv4, adv_o;

  elem_t                 s1_r;
  meta_t                 meta2_r, meta3_r, meta4_r, meta_o_r;
  logic [T1_W-1:0]       t1_r;
  logic [T2_W-1:0]       t2_r;
  logic [T3_W-1:0]       t3_r;
  logic [SIZE_FLD_W-1:0] x2_r, y2_r, x3_r;
  logic [BASE_W-1:0]     base2_r, base3_r, base4_r;
  logic [ADDR_W-1:0]     addr_o_r;
  meta_t                 meta1;

  assign adv_o  = !vo_r || out_ch.ready;
  assign adv4   = !v4_r || adv_o;
  assign adv3   = !v3_r || adv4;
  assign adv2   = !v2_r || adv3;
  assign adv1   = !v1_r || adv2;
  assign in_rdy = adv1;

  assign meta1 = '{status: s1_r.status, row: s1_r.row, col: s1_r.col,
                   inr: s1_r.inr, last: s1_r.last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1)  v1_r <= push;
      if (adv2)  v2_r <= v1_r;
      if (adv3)  v3_r <= v2_r;
      if (adv4)  v4_r <= v3_r;
      if (adv_o) vo_r <= v4_r;
    end
  end

  // Offset = ((channel * S2 + z) * S1 + y) * S0 + x, one product per stage.
  always_ff @(posedge clk) begin
    if (adv1) s1_r <= elem;
    if (adv2) begin
      meta2_r <= meta1;
      t1_r    <= T1_W'(s1_r.ch) * T1_W'(geom[2].size) + T1_W'(s1_r.z);
      y2_r    <= s1_r.y;
      x2_r    <= s1_r.x;
      base2_r <= s1_r.base;
    end
    if (adv3) begin
      meta3_r <= meta2_r;
      t2_r    <= T2_W'(t1_r) * T2_W'(geom[1].size) + T2_W'(y2_r);
      x3_r    <= x2_r;
      base3_r <= base2_r;
    end
    if (adv4) begin
      meta4_r <= meta3_r;
      t3_r    <= T3_W'(t2_r) * T3_W'(geom[0].size) + T3_W'(x3_r);
      base4_r <= base3_r;
    end
    if (adv_o) begin
      meta_o_r <= meta4_r;
      addr_o_r <= meta4_r.inr ? (ADDR_W'(base4_r) + ADDR_W'(t3_r)) : '0;
    end
  end

  assign out_ch.valid          = vo_r;
  assign out_ch.status         = meta_o_r.status;
  assign out_ch.matrix_row     = meta_o_r.row;
  assign out_ch.matrix_column  = meta_o_r.col;
  assign out_ch.source_address = addr_o_r;
  assign out_ch.in_range       = meta_o_r.inr;
  assign out_ch.last_element   = meta_o_r.last;

endmodule
